>>> rtl/mcgm_pkg.sv
// shared types, codes and constant tables of the month calendar grid marker
package mcgm_pkg;

    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int HL_W       = 2;
    localparam int MD_W       = MONTH_W + DAY_W;
    localparam int DIVIDEND_W = 12;
    localparam int DIVISOR_W  = 7;
    localparam int QUO_W      = 6;
    localparam int REM_K_W    = 7;
    localparam int CENT_W     = 5;
    localparam int SUM_W      = 9;
    localparam int MTERM_W    = 6;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RENDER = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CELL     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADMARK  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADMONTH = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

    localparam logic [HL_W-1:0] HL_NONE    = 2'd0;
    localparam logic [HL_W-1:0] HL_TODAY   = 2'd1;
    localparam logic [HL_W-1:0] HL_MARKED  = 2'd2;
    localparam logic [HL_W-1:0] HL_HOLIDAY = 2'd3;

    localparam logic [YEAR_W-1:0]    YEAR_MIN  = 12'd1970;
    localparam logic [YEAR_W-1:0]    YEAR_MAX  = 12'd2200;
    localparam logic [MONTH_W-1:0]   MONTH_MIN = 4'd1;
    localparam logic [MONTH_W-1:0]   MONTH_MAX = 4'd12;
    localparam logic [MONTH_W-1:0]   MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0]   MONTH_MAR = 4'd3;
    localparam logic [DAY_W-1:0]     DAYS_LEAP = 5'd29;
    localparam logic [DIVISOR_W-1:0] CENTURY   = 7'd100;
    localparam logic [DIVISOR_W-1:0] WEEK      = 7'd7;
    localparam logic [REM_K_W-1:0]   LAST_YY   = 7'd99;
    localparam logic [COL_W-1:0]     LAST_COL  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STAT,
        S_MARK_RD,
        S_MARK_CMP,
        S_MARK_END,
        S_DIV100,
        S_SUM,
        S_MOD7,
        S_DAY,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [QUO_W-1:0]      quo;
        logic [DIVIDEND_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                   len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(13 * (m + 1) / 5) with january and february counted as months 13 and 14
    function automatic logic [MTERM_W-1:0] zeller_mterm(input logic [MONTH_W-1:0] m);
        logic [MTERM_W-1:0] t;
        case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    function automatic logic on_holiday(input logic [MONTH_W-1:0] m,
                                        input logic [DAY_W-1:0] d);
        logic hit;
        case (m)
            4'd1:    hit = (d >= 5'd1)  && (d <= 5'd3);
            4'd2:    hit = (d >= 5'd10) && (d <= 5'd17);
            4'd4:    hit = (d >= 5'd4)  && (d <= 5'd6);
            4'd5:    hit = (d >= 5'd1)  && (d <= 5'd5);
            4'd6:    hit = (d >= 5'd10) && (d <= 5'd12);
            4'd10:   hit = (d >= 5'd1)  && (d <= 5'd7);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

>>> rtl/mcgm_if.sv
// valid/ready channel interfaces for requests and results

interface mcgm_in_if;
    import mcgm_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;

    modport source (output valid, action, year, month, day, input ready);
    modport sink   (input valid, action, year, month, day, output ready);
endinterface

interface mcgm_out_if;
    import mcgm_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    grid_row;
    logic [COL_W-1:0]    grid_col;
    logic [DAY_W-1:0]    day_number;
    logic [HL_W-1:0]     highlight;
    logic                last;

    modport source (output valid, status, grid_row, grid_col, day_number, highlight, last,
                    input ready);
    modport sink   (input valid, status, grid_row, grid_col, day_number, highlight, last,
                    output ready);
endinterface

>>> rtl/month_calendar_grid_marker.sv
// top level of the month calendar grid marker: sequencer, mark list and result register
//
// Requests arrive on i_in (action, year, month, day) and results leave on o_out,
// both valid/ready channels; a transaction moves when valid and ready are high.
// Clear and add give one status result; render gives one cell result per day of
// the month, the final one flagged by last; a bad year or month gives one status
// result instead. Action 3 is dropped with no result. i_in.ready is high only
// while the sequencer is idle; one request is worked on at a time. Timing is set
// by the shared compare/subtract unit and the single read port of the mark list:
// add scans the marks until a match or the end of the list; render divides the
// year by 100 and the Zeller sum by 7 through repeated subtraction, then scans
// the marks for each day of the month, stopping at a match. Results sit in an
// output register; while o_out.ready is low the sequencer holds at the next
// result and the request side stays closed until the last result is loaded.
// Reset empties the mark list (count to zero), drops any pending result and
// returns the sequencer to idle.
module month_calendar_grid_marker #(
    parameter int MARK_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcgm_in_if.sink     i_in,
    mcgm_out_if.source  o_out
);
    import mcgm_pkg::*;

    localparam int CW = $clog2(MARK_SLOTS + 1);
    localparam int IW = MARK_SLOTS > 1 ? $clog2(MARK_SLOTS) : 1;

    t_state               r_state, n_state;
    logic [YEAR_W-1:0]    r_year, n_year;
    logic [MONTH_W-1:0]   r_month, n_month;
    logic [DAY_W-1:0]     r_day, n_day;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_hit, n_hit;
    logic                 r_render, n_render;
    logic [MD_W-1:0]      r_md, n_md;
    logic [REM_K_W-1:0]   r_k, n_k;
    logic [CENT_W-1:0]    r_j, n_j;
    logic [DAY_W-1:0]     r_cur, n_cur;
    logic [DAY_W-1:0]     r_total, n_total;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [COL_W-1:0]     r_col, n_col;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic                 r_ov, n_ov;
    logic [STATUS_W-1:0]  r_o_status, n_o_status;
    logic [ROW_W-1:0]     r_o_row, n_o_row;
    logic [COL_W-1:0]     r_o_col, n_o_col;
    logic [DAY_W-1:0]     r_o_day, n_o_day;
    logic [HL_W-1:0]      r_o_hl, n_o_hl;
    logic                 r_o_last, n_o_last;

    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;
    logic                 w_ram_we;
    logic [MD_W-1:0]      w_ram_rdata;
    logic                 w_out_free;
    logic                 w_leap;
    logic [SUM_W-1:0]     w_sum;
    logic                 w_match;

    mcgm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    mcgm_ram #(
        .WIDTH (MD_W),
        .DEPTH (MARK_SLOTS)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (r_md),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_out_free = !r_ov || o_out.ready;
    assign w_match    = w_ram_rdata == r_md;

    // the +1 of the congruence and the +6 that moves saturday to sunday cancel mod 7
    assign w_sum = SUM_W'(zeller_mterm(r_month)) + SUM_W'(r_k) + SUM_W'(r_k >> 2)
                 + SUM_W'(r_j >> 2) + SUM_W'({r_j, 2'b00}) + SUM_W'(r_j);

    // stored year is already one less for january and february
    assign w_leap = (r_year[1:0] == 2'd3) && ((r_k != LAST_YY) || (r_j[1:0] == 2'd3));

    always_comb begin
        n_state    = r_state;
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_count    = r_count;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_render   = r_render;
        n_md       = r_md;
        n_k        = r_k;
        n_j        = r_j;
        n_cur      = r_cur;
        n_total    = r_total;
        n_row      = r_row;
        n_col      = r_col;
        n_status   = r_status;
        n_ov       = r_ov && !o_out.ready;
        n_o_status = r_o_status;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_day    = r_o_day;
        n_o_hl     = r_o_hl;
        n_o_last   = r_o_last;
        w_div_req  = '0;
        w_ram_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_month = i_in.month;
                    n_day   = i_in.day;
                    n_md    = {i_in.month, i_in.day};
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    case (i_in.action)
                        ACT_CLEAR: begin
                            n_count  = '0;
                            n_status = ST_CLEARED;
                            n_state  = S_STAT;
                        end
                        ACT_ADD: begin
                            n_render = 1'b0;
                            if (i_in.month < MONTH_MIN || i_in.month > MONTH_MAX
                                || i_in.day == '0) begin
                                n_status = ST_BADMARK;
                                n_state  = S_STAT;
                            end else if (r_count == '0) begin
                                n_state = S_MARK_END;
                            end else begin
                                n_state = S_MARK_RD;
                            end
                        end
                        ACT_RENDER: begin
                            n_render = 1'b1;
                            if (i_in.year < YEAR_MIN || i_in.year > YEAR_MAX
                                || i_in.month < MONTH_MIN || i_in.month > MONTH_MAX) begin
                                n_status = ST_BADMONTH;
                                n_state  = S_STAT;
                            end else begin
                                n_year = (i_in.month < MONTH_MAR) ?
                                         i_in.year - YEAR_W'(1) : i_in.year;
                                w_div_req.start    = 1'b1;
                                w_div_req.dividend = DIVIDEND_W'(n_year);
                                w_div_req.divisor  = CENTURY;
                                n_state = S_DIV100;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_STAT: begin
                if (w_out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_row    = '0;
                    n_o_col    = '0;
                    n_o_day    = '0;
                    n_o_hl     = HL_NONE;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MARK_RD: begin
                n_state = S_MARK_CMP;
            end
            S_MARK_CMP: begin
                if (w_match) begin
                    n_hit = 1'b1;
                end
                if (w_match || (r_idx + CW'(1) == r_count)) begin
                    n_state = r_render ? S_EMIT : S_MARK_END;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_MARK_RD;
                end
            end
            S_MARK_END: begin
                if (r_hit) begin
                    n_status = ST_DUP;
                end else if (r_count == CW'(MARK_SLOTS)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ram_we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_status = ST_ADDED;
                end
                n_state = S_STAT;
            end
            S_DIV100: begin
                if (w_div_rsp.done) begin
                    n_k     = w_div_rsp.rem[REM_K_W-1:0];
                    n_j     = w_div_rsp.quo[CENT_W-1:0];
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DIVIDEND_W'(w_sum);
                w_div_req.divisor  = WEEK;
                n_total = (r_month == MONTH_FEB && w_leap) ? DAYS_LEAP : month_len(r_month);
                n_state = S_MOD7;
            end
            S_MOD7: begin
                if (w_div_rsp.done) begin
                    n_col   = w_div_rsp.rem[COL_W-1:0];
                    n_row   = '0;
                    n_cur   = DAY_W'(1);
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                n_md    = {r_month, r_cur};
                n_idx   = '0;
                n_hit   = 1'b0;
                n_state = (r_count == '0) ? S_EMIT : S_MARK_RD;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = ST_CELL;
                    n_o_row    = r_row;
                    n_o_col    = r_col;
                    n_o_day    = r_cur;
                    n_o_last   = r_cur == r_total;
                    if (r_cur == r_day) begin
                        n_o_hl = HL_TODAY;
                    end else if (r_hit) begin
                        n_o_hl = HL_MARKED;
                    end else if (on_holiday(r_month, r_cur)) begin
                        n_o_hl = HL_HOLIDAY;
                    end else begin
                        n_o_hl = HL_NONE;
                    end
                    if (r_cur == r_total) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur = r_cur + DAY_W'(1);
                        if (r_col == LAST_COL) begin
                            n_col = '0;
                            n_row = r_row + ROW_W'(1);
                        end else begin
                            n_col = r_col + COL_W'(1);
                        end
                        n_state = S_DAY;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year     <= n_year;
        r_month    <= n_month;
        r_day      <= n_day;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_render   <= n_render;
        r_md       <= n_md;
        r_k        <= n_k;
        r_j        <= n_j;
        r_cur      <= n_cur;
        r_total    <= n_total;
        r_row      <= n_row;
        r_col      <= n_col;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_day    <= n_o_day;
        r_o_hl     <= n_o_hl;
        r_o_last   <= n_o_last;
    end

    assign i_in.ready       = r_state == S_IDLE;
    assign o_out.valid      = r_ov;
    assign o_out.status     = r_o_status;
    assign o_out.grid_row   = r_o_row;
    assign o_out.grid_col   = r_o_col;
    assign o_out.day_number = r_o_day;
    assign o_out.highlight  = r_o_hl;
    assign o_out.last       = r_o_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MARK_SLOTS))
        else $error("mark count beyond list size");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> r_count < CW'(MARK_SLOTS))
        else $error("mark written into a full list");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_CELL) |-> (o_out.last && o_out.day_number == '0))
        else $error("status transaction not flagged last");

    a_cell_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_CELL)
        |-> (o_out.grid_col <= LAST_COL && o_out.day_number != '0))
        else $error("cell transaction outside the grid");

    a_no_load_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> (r_ov && $stable(r_o_day) && $stable(r_o_status)))
        else $error("pending result overwritten");
endmodule

>>> rtl/mcgm_ram.sv
// generic single write port ram with registered read
module mcgm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mcgm_div.sv
// shared compare and subtract unit, one repeated-subtraction step per cycle
module mcgm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcgm_pkg::t_div_req i_req,
    output mcgm_pkg::t_div_rsp o_rsp
);
    import mcgm_pkg::*;

    logic                  r_busy, n_busy;
    logic [DIVIDEND_W-1:0] r_acc, n_acc;
    logic [DIVISOR_W-1:0]  r_div, n_div;
    logic [QUO_W-1:0]      r_quo, n_quo;
    logic                  w_fits;

    assign w_fits = r_acc >= DIVIDEND_W'(r_div);

    always_comb begin
        n_busy = r_busy;
        n_acc  = r_acc;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_acc  = i_req.dividend;
            n_div  = i_req.divisor;
            n_quo  = '0;
        end else if (r_busy) begin
            if (w_fits) begin
                n_acc = r_acc - DIVIDEND_W'(r_div);
                n_quo = r_quo + QUO_W'(1);
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_busy && !w_fits;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_acc;
endmodule

>>> bench/tb_month_calendar_grid_marker.sv
// testbench of the month calendar grid marker: table-driven and random requests
module tb_month_calendar_grid_marker;
    import mcgm_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 430;
    localparam int IDLE_PCT      = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MARK_SLOTS    = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROW_W-1:0]    grid_row;
        logic [COL_W-1:0]    grid_col;
        logic [DAY_W-1:0]    day_number;
        logic [HL_W-1:0]     highlight;
        logic                last;
    } t_grid_cell;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic                fixed;
        logic [STATUS_W-1:0] fixed_status;
    } t_request_row;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   errors;
    int   cycle_count;
    int   accepted_items;

    mcgm_in_if  in_ch ();
    mcgm_out_if out_ch ();

    month_calendar_grid_marker #(.MARK_SLOTS(MARK_SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // calendar facts kept by the bench
    int days_in [12]     = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int festive_month [6] = '{1, 2, 4, 5, 6, 10};
    int festive_from [6]  = '{1, 10, 4, 1, 10, 1};
    int festive_to [6]    = '{3, 17, 6, 5, 12, 7};

    logic [MD_W-1:0] mark_store [MARK_SLOTS];
    int              mark_total;
    t_grid_cell      fresh_cells [$];
    t_grid_cell      awaited_cells [$];

    t_request_row directed_rows [0:24] = '{
        '{ACT_CLEAR,  12'd0,    4'd0,  5'd0,  1'b1, ST_CLEARED},
        '{ACT_RENDER, 12'd1969, 4'd1,  5'd1,  1'b1, ST_BADMONTH},
        '{ACT_RENDER, 12'd2201, 4'd12, 5'd1,  1'b1, ST_BADMONTH},
        '{ACT_RENDER, 12'd0,    4'd0,  5'd0,  1'b1, ST_BADMONTH},
        '{ACT_RENDER, 12'd4095, 4'd15, 5'd31, 1'b1, ST_BADMONTH},
        '{ACT_RENDER, 12'd2000, 4'd0,  5'd5,  1'b1, ST_BADMONTH},
        '{ACT_RENDER, 12'd2000, 4'd13, 5'd5,  1'b1, ST_BADMONTH},
        '{ACT_ADD,    12'd0,    4'd0,  5'd5,  1'b1, ST_BADMARK},
        '{ACT_ADD,    12'd4095, 4'd13, 5'd5,  1'b1, ST_BADMARK},
        '{ACT_ADD,    12'd0,    4'd15, 5'd31, 1'b1, ST_BADMARK},
        '{ACT_ADD,    12'd0,    4'd3,  5'd0,  1'b1, ST_BADMARK},
        '{ACT_ADD,    12'd0,    4'd1,  5'd1,  1'b1, ST_ADDED},
        '{ACT_ADD,    12'd0,    4'd1,  5'd1,  1'b1, ST_DUP},
        '{ACT_ADD,    12'd0,    4'd2,  5'd31, 1'b1, ST_ADDED},
        '{ACT_ADD,    12'd0,    4'd2,  5'd29, 1'b0, ST_CELL},
        '{ACT_ADD,    12'd4095, 4'd12, 5'd31, 1'b0, ST_CELL},
        '{ACT_UNUSED, 12'd4095, 4'd15, 5'd31, 1'b0, ST_CELL},
        '{ACT_RENDER, 12'd1970, 4'd1,  5'd2,  1'b0, ST_CELL},
        '{ACT_RENDER, 12'd2200, 4'd12, 5'd31, 1'b0, ST_CELL},
        '{ACT_RENDER, 12'd2000, 4'd2,  5'd31, 1'b0, ST_CELL},
        '{ACT_RENDER, 12'd2100, 4'd2,  5'd0,  1'b0, ST_CELL},
        '{ACT_RENDER, 12'd2024, 4'd10, 5'd7,  1'b0, ST_CELL},
        '{ACT_RENDER, 12'd2023, 4'd4,  5'd5,  1'b0, ST_CELL},
        '{ACT_RENDER, 12'd2024, 4'd5,  5'd3,  1'b0, ST_CELL},
        '{ACT_CLEAR,  12'd4095, 4'd15, 5'd31, 1'b1, ST_CLEARED}
    };

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic bit mark_seen(input logic [MD_W-1:0] md);
        for (int i = 0; i < mark_total; i++) begin
            if (mark_store[i] == md) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit festive(input int m, input int d);
        for (int i = 0; i < 6; i++) begin
            if (festive_month[i] == m && d >= festive_from[i] && d <= festive_to[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_grid_cell status_cell(input logic [STATUS_W-1:0] st);
        t_grid_cell c;
        c = '0;
        c.status = st;
        c.last = 1'b1;
        return c;
    endfunction

    // works out the results of one request and updates the mark list
    function automatic void calendar_outcome(input logic [ACTION_W-1:0] act,
                                             input logic [YEAR_W-1:0]   yr,
                                             input logic [MONTH_W-1:0]  mon,
                                             input logic [DAY_W-1:0]    dd);
        int y, m, k, j, h, first, total, pos;
        logic [MD_W-1:0] md;
        t_grid_cell c;
        fresh_cells.delete();
        case (act)
            ACT_CLEAR: begin
                mark_total = 0;
                fresh_cells.push_back(status_cell(ST_CLEARED));
            end
            ACT_ADD: begin
                md = {mon, dd};
                if (mon < MONTH_MIN || mon > MONTH_MAX || dd == '0) begin
                    fresh_cells.push_back(status_cell(ST_BADMARK));
                end else if (mark_seen(md)) begin
                    fresh_cells.push_back(status_cell(ST_DUP));
                end else if (mark_total >= MARK_SLOTS) begin
                    fresh_cells.push_back(status_cell(ST_FULL));
                end else begin
                    mark_store[mark_total] = md;
                    mark_total++;
                    fresh_cells.push_back(status_cell(ST_ADDED));
                end
            end
            ACT_RENDER: begin
                if (yr < YEAR_MIN || yr > YEAR_MAX || mon < MONTH_MIN || mon > MONTH_MAX) begin
                    fresh_cells.push_back(status_cell(ST_BADMONTH));
                end else begin
                    y = int'(yr);
                    m = int'(mon);
                    // january and february count as months of the year before
                    if (m < 3) begin
                        m += 12;
                        y -= 1;
                    end
                    k = y % 100;
                    j = y / 100;
                    h = (1 + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
                    first = (h + 6) % 7;
                    total = days_in[int'(mon) - 1];
                    if (mon == MONTH_FEB && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0))
                        total = 29;
                    for (int d = 1; d <= total; d++) begin
                        pos = first + d - 1;
                        c = '0;
                        c.status = ST_CELL;
                        c.grid_row = ROW_W'(pos / 7);
                        c.grid_col = COL_W'(pos % 7);
                        c.day_number = DAY_W'(d);
                        if (DAY_W'(d) == dd) c.highlight = HL_TODAY;
                        else if (mark_seen({mon, DAY_W'(d)})) c.highlight = HL_MARKED;
                        else if (festive(int'(mon), d)) c.highlight = HL_HOLIDAY;
                        else c.highlight = HL_NONE;
                        c.last = (d == total);
                        fresh_cells.push_back(c);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic offer(input logic [ACTION_W-1:0] act,
                         input logic [YEAR_W-1:0]   yr,
                         input logic [MONTH_W-1:0]  mon,
                         input logic [DAY_W-1:0]    dd,
                         input bit                  fixed = 1'b0,
                         input logic [STATUS_W-1:0] fixed_st = ST_CELL);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.year   <= yr;
        in_ch.month  <= mon;
        in_ch.day    <= dd;
        do @(posedge i_clk); while (!in_ch.ready);
        calendar_outcome(act, yr, mon, dd);
        if (fixed) begin
            awaited_cells.push_back(status_cell(fixed_st));
        end else begin
            foreach (fresh_cells[i]) awaited_cells.push_back(fresh_cells[i]);
        end
        if (act != ACT_UNUSED) accepted_items++;
        @(negedge i_clk);
    endtask

    // hold the request side until every awaited result is out
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (awaited_cells.size() != 0);
    endtask

    function automatic logic [YEAR_W-1:0] pick_year();
        case ($urandom_range(9))
            0:       return YEAR_MIN;
            1:       return YEAR_MAX;
            2:       return 12'd2000;
            3:       return 12'd2100;
            default: return YEAR_W'($urandom_range(1970, 2200));
        endcase
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_grid_cell want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_cells.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual status %0d day %0d",
                         $time, out_ch.status, out_ch.day_number);
            end else begin
                want = awaited_cells.pop_front();
                check_field("status", want.status, out_ch.status);
                check_field("grid_row", want.grid_row, out_ch.grid_row);
                check_field("grid_col", want.grid_col, out_ch.grid_col);
                check_field("day_number", want.day_number, out_ch.day_number);
                check_field("highlight", want.highlight, out_ch.highlight);
                check_field("last", want.last, out_ch.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int base, focus, start, n;
        logic [MONTH_W-1:0] mon;
        logic [DAY_W-1:0]   dd;
        i_rst_n = 1'b0;
        calm = 1'b0;
        errors = 0;
        cycle_count = 0;
        accepted_items = 0;
        mark_total = 0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_CLEAR;
        in_ch.year = '0;
        in_ch.month = '0;
        in_ch.day = '0;
        out_ch.ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            offer(directed_rows[r].action, directed_rows[r].year, directed_rows[r].month,
                  directed_rows[r].day, directed_rows[r].fixed, directed_rows[r].fixed_status);
        end
        drain();

        base = accepted_items;
        while (accepted_items - base < RANDOM_ITEMS) begin
            // a stretch with no idling on either side
            calm = (accepted_items - base >= 200) && (accepted_items - base < 280);
            if ($urandom_range(19) == 0) drain();
            case ($urandom_range(9))
                0, 1, 2: begin
                    // clear, fill the list mostly in one month, then lay that month out
                    offer(ACT_CLEAR, YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom));
                    focus = $urandom_range(1, 12);
                    start = $urandom_range(0, 30);
                    n = $urandom_range(4, 22);
                    for (int i = 0; i < n; i++) begin
                        mon = ($urandom_range(3) == 0) ? MONTH_W'($urandom_range(1, 12))
                                                       : MONTH_W'(focus);
                        dd = ($urandom_range(9) == 0) ? DAY_W'($urandom_range(1, 31))
                                                      : DAY_W'((start + i) % 31 + 1);
                        offer(ACT_ADD, YEAR_W'($urandom), mon, dd);
                    end
                    repeat ($urandom_range(1, 3))
                        offer(ACT_RENDER, pick_year(), MONTH_W'(focus),
                              DAY_W'($urandom_range(0, 31)));
                end
                3: offer(ACT_CLEAR, YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom));
                4, 5: offer(ACT_ADD, YEAR_W'($urandom), MONTH_W'($urandom_range(1, 12)),
                            DAY_W'($urandom_range(1, 31)));
                6, 7: offer(ACT_RENDER, pick_year(), MONTH_W'($urandom_range(1, 12)),
                            DAY_W'($urandom_range(0, 31)));
                default: offer(ACTION_W'($urandom_range(3)), YEAR_W'($urandom),
                               MONTH_W'($urandom), DAY_W'($urandom));
            endcase
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mcgm_pkg.sv
rtl/mcgm_if.sv
rtl/mcgm_ram.sv
rtl/mcgm_div.sv
rtl/month_calendar_grid_marker.sv
bench/tb_month_calendar_grid_marker.sv
